>>> sv/ddo_pkg.sv
package ddo_pkg;

    localparam int GainW   = 24;
    localparam int InvBwW  = 24;
    localparam int DtW     = 16;
    localparam int RawW    = 24;
    localparam int PosW    = 32;
    localparam int AngW    = 32;
    localparam int VelW    = 24;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CFG_SPEED_GAIN = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_INV_BASE_W = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_STEP_TIME  = 2'd2;

    localparam logic [GainW-1:0]  GAIN_RESET  = 24'd964752;
    localparam logic [InvBwW-1:0] INVBW_RESET = 24'd179549;
    localparam logic [DtW-1:0]    DT_RESET    = 16'd655;

    localparam logic [31:0] GAIN_COMP  = 32'd2608131496;
    localparam logic [31:0] RAD_TO_BAM = 32'd683565276;

    typedef struct packed {
        logic signed [RawW-1:0] left_raw_speed;
        logic signed [RawW-1:0] right_raw_speed;
    } ddo_in_t;

    typedef struct packed {
        logic signed [PosW-1:0] position_x;
        logic signed [PosW-1:0] position_y;
        logic [AngW-1:0]        heading_angle;
        logic signed [VelW-1:0] linear_velocity;
        logic signed [VelW-1:0] angular_velocity;
    } ddo_out_t;

    typedef struct packed {
        logic [CfgIdxW-1:0] index;
        logic [GainW-1:0]   data;
    } ddo_cfg_t;

    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'd536870912;
                5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;
                5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;
                5'd5: r = 32'd21354465;
                5'd6: r = 32'd10679838;
                5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;
                5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                5'd24: r = 32'd41;
                5'd25: r = 32'd20;
                5'd26: r = 32'd10;
                5'd27: r = 32'd5;
                5'd28: r = 32'd3;
                5'd29: r = 32'd1;
                5'd30: r = 32'd1;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> sv/ddo_if.sv
interface ddo_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/ddo_smul.sv
// serial signed multiplier: radix-4 digit of b per cycle, a held whole
module ddo_smul
    import ddo_pkg::*;
#(
    parameter int AW = 34,
    parameter int BW = 34
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [AW-1:0]   a,
    input  logic signed [BW-1:0]   b,
    output logic                   done,
    output logic signed [AW+BW-1:0] p
);
    localparam int Steps = (BW + 1) / 2;
    localparam int BXW   = 2 * Steps;
    localparam int CW    = $clog2(Steps + 1);

    logic signed [AW-1:0]    a_reg;
    logic [BXW-1:0]          b_reg, b_next;
    logic signed [AW+BXW-1:0] acc_reg, acc_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic signed [AW+2:0]    part;
    logic signed [AW+2:0]    a_ext;
    logic                    top_digit;

    always_comb
    begin
        top_digit = (cnt_reg == CW'(Steps - 1));
        a_ext     = (AW+3)'(a_reg);
        // last digit of a sign-extended b is signed
        case ({top_digit, b_reg[1:0]})
            3'b000:  part = '0;
            3'b001:  part = a_ext;
            3'b010:  part = a_ext <<< 1;
            3'b011:  part = a_ext + (a_ext <<< 1);
            3'b100:  part = '0;
            3'b101:  part = a_ext;
            3'b110:  part = -(a_ext <<< 1);
            default: part = -a_ext;
        endcase
        acc_next  = acc_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            b_next    = BXW'($signed(b));
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = (acc_reg >>> 2) + ((AW+BXW)'(part) <<< (BXW - 2));
            b_next   = b_reg >> 2;
            cnt_next = cnt_reg + CW'(1);
            if (top_digit)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            a_reg <= a;
        acc_reg <= acc_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign p    = (AW+BW)'(acc_reg);
endmodule

>>> sv/diff_drive_odometry.sv
// channel   dir  payload                                             handshake
// in_ch     in   left_raw_speed, right_raw_speed                     valid/ready
// out_ch    out  position_x/y, heading_angle, linear/angular_velocity valid/ready
// cfg_ch    in   index, data (speed_gain, inverse_base_width, step_time) valid/ready
// one item at a time; each item passes through these steps in order:
// one accept step, seven serial multiplies on the 2-bit-digit multiplier,
// ROTATION_STEPS rotation steps and one write-back step
// reset clears pose to zero and loads register defaults
// the result sits in an output register; the next item is taken while it waits,
// but a result still unread holds the following item in its write-back cycle
module diff_drive_odometry
    import ddo_pkg::*;
#(
    parameter int ROTATION_STEPS = 24
)
(
    input  logic clk,
    input  logic rst_n,
    ddo_if.sink   in_ch,
    ddo_if.source out_ch,
    ddo_if.sink   cfg_ch
);
    localparam int MW = 34;
    localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_WAIT = 3'd2,
                           S_ROT = 3'd3, S_DONE = 3'd4;
    localparam logic [2:0] M_V = 3'd0, M_WA = 3'd1, M_WB = 3'd2, M_D = 3'd3,
                           M_H1 = 3'd4, M_H2 = 3'd5, M_X = 3'd6;

    logic [GainW-1:0]  gain_reg;
    logic [InvBwW-1:0] invbw_reg;
    logic [DtW-1:0]    dt_reg;
    logic signed [PosW-1:0] px_reg, py_reg;
    logic [AngW-1:0]   ph_reg;

    logic [2:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic [4:0] it_reg, it_next;
    logic signed [RawW:0] sum_reg, dif_reg;
    logic signed [VelW-1:0] v_reg, w_reg;
    logic signed [47:0] tmp_reg;
    logic signed [47:0] x_reg, y_reg;
    logic signed [32:0] z_reg;
    logic [AngW-1:0] nh_reg;
    logic signed [33:0] d_reg;
    logic out_valid_reg;
    ddo_out_t out_reg;

    logic start;
    logic signed [MW-1:0] ma, mb;
    logic mdone;
    logic signed [2*MW-1:0] mp;

    ddo_smul #(.AW(MW), .BW(MW)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(start), .a(ma), .b(mb),
        .done(mdone), .p(mp)
    );

    function automatic logic signed [67:0] rnd(input logic signed [67:0] v,
                                               input int s);
        return (v + (68'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [VelW-1:0] sat24(input logic signed [67:0] v);
        if (v > 68'sd8388607) return 24'sh7FFFFF;
        else if (v < -68'sd8388608) return 24'sh800000;
        return VelW'(v);
    endfunction

    function automatic logic signed [PosW-1:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) return 32'sh7FFFFFFF;
        else if (v < -68'sd2147483648) return 32'sh80000000;
        return PosW'(v);
    endfunction

    // operand selection for each multiply
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (op_reg)
            M_V:  begin ma = MW'(sum_reg); mb = MW'({1'b0, gain_reg}); end
            M_WA: begin ma = MW'(dif_reg); mb = MW'({1'b0, gain_reg}); end
            M_WB: begin ma = MW'(tmp_reg); mb = MW'({1'b0, invbw_reg}); end
            M_D:  begin ma = MW'(v_reg); mb = MW'({1'b0, dt_reg}); end
            M_H1: begin ma = MW'(w_reg); mb = MW'({1'b0, dt_reg}); end
            M_H2: begin ma = MW'(tmp_reg); mb = MW'({1'b0, RAD_TO_BAM}); end
            M_X:  begin ma = MW'(d_reg); mb = MW'({1'b0, GAIN_COMP}); end
            default: ;
        endcase
    end

    logic signed [67:0] pw;
    logic [AngW-1:0] tt;
    logic signed [47:0] xs, ys;
    logic [4:0] last_it;

    assign pw      = 68'(mp);
    assign start   = (state_reg == S_MUL);
    assign xs      = x_reg >>> it_reg;
    assign ys      = y_reg >>> it_reg;
    assign last_it = 5'(ROTATION_STEPS - 1);
    assign tt      = nh_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        it_next    = it_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_ch.valid)
                begin
                    state_next = S_MUL;
                    op_next    = M_V;
                end
            S_MUL: state_next = S_WAIT;
            S_WAIT:
                if (mdone)
                begin
                    if (op_reg == M_X)
                    begin
                        state_next = S_ROT;
                        it_next    = '0;
                    end
                    else
                    begin
                        state_next = S_MUL;
                        op_next    = op_reg + 3'd1;
                    end
                end
            S_ROT:
                if (it_reg == last_it)
                    state_next = S_DONE;
                else
                    it_next = it_reg + 5'd1;
            S_DONE:
                if (!out_valid_reg || out_ch.ready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= M_V;
            it_reg        <= '0;
            out_valid_reg <= 1'b0;
            gain_reg      <= GAIN_RESET;
            invbw_reg     <= INVBW_RESET;
            dt_reg        <= DT_RESET;
            px_reg        <= '0;
            py_reg        <= '0;
            ph_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            it_reg    <= it_next;
            if (cfg_ch.valid)
            begin
                unique case (cfg_ch.data.index)
                    CFG_SPEED_GAIN: gain_reg  <= cfg_ch.data.data;
                    CFG_INV_BASE_W: invbw_reg <= cfg_ch.data.data;
                    CFG_STEP_TIME:  dt_reg    <= cfg_ch.data.data[DtW-1:0];
                    default: ;
                endcase
            end
            if (state_reg == S_DONE && (!out_valid_reg || out_ch.ready))
            begin
                out_valid_reg <= 1'b1;
                px_reg <= sat32(68'(px_reg) + rnd(68'(x_reg), 8));
                py_reg <= sat32(68'(py_reg) + rnd(68'(y_reg), 8));
                ph_reg <= nh_reg;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            sum_reg <= (RawW+1)'(in_ch.data.left_raw_speed)
                     + (RawW+1)'(in_ch.data.right_raw_speed);
            dif_reg <= (RawW+1)'(in_ch.data.right_raw_speed)
                     - (RawW+1)'(in_ch.data.left_raw_speed);
        end
        if (state_reg == S_WAIT && mdone)
        begin
            case (op_reg)
                M_V:  v_reg   <= sat24(rnd(pw, 17));
                M_WA: tmp_reg <= 48'(rnd(pw, 16));
                M_WB: w_reg   <= sat24(rnd(pw, 16));
                M_D:  d_reg   <= 34'(rnd(pw, 8));
                M_H1: tmp_reg <= 48'(rnd(pw, 8));
                M_H2: nh_reg  <= ph_reg + AngW'(rnd(pw, 24));
                M_X:
                begin
                    // quadrant fold, then z as a signed angle
                    if (tt[31] ^ tt[30])
                    begin
                        x_reg <= -48'(rnd(pw, 32));
                        z_reg <= 33'($signed(tt - 32'h80000000));
                    end
                    else
                    begin
                        x_reg <= 48'(rnd(pw, 32));
                        z_reg <= 33'($signed(tt));
                    end
                    y_reg <= '0;
                end
                default: ;
            endcase
        end
        if (state_reg == S_ROT)
        begin
            if (!z_reg[32])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - 33'(atan_bam(it_reg));
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + 33'(atan_bam(it_reg));
            end
        end
        if (state_reg == S_DONE && (!out_valid_reg || out_ch.ready))
        begin
            out_reg.position_x       <= sat32(68'(px_reg) + rnd(68'(x_reg), 8));
            out_reg.position_y       <= sat32(68'(py_reg) + rnd(68'(y_reg), 8));
            out_reg.heading_angle    <= nh_reg;
            out_reg.linear_velocity  <= v_reg;
            out_reg.angular_velocity <= w_reg;
        end
    end

    a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == S_IDLE)
        else $error("input taken outside idle");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> state_reg == S_MUL)
        else $error("item not started");
    a_rot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROT) |-> it_reg <= last_it)
        else $error("rotation step overrun");
endmodule
